### sv/tta_pkg.sv
`timescale 1ns / 1ps

package tta_pkg;

  // Operation codes carried on the kind field.
  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_SUB    = 3'd1,
    KIND_LESS   = 3'd2,
    KIND_EQUAL  = 3'd3,
    KIND_TO_TER = 3'd4,
    KIND_TO_BIN = 3'd5
  } kind_t;

  localparam int unsigned TRITS     = 4;
  localparam int unsigned WORD_W    = 2 * TRITS;
  localparam int unsigned NUMBER_W  = 7;

  // Place weights of the upper trits, and W81, the modulus of a word.
  localparam logic [NUMBER_W-1:0] W27 = NUMBER_W'(3 * 3 * 3);
  localparam logic [NUMBER_W-1:0] W9  = NUMBER_W'(3 * 3);
  localparam logic [NUMBER_W-1:0] W3  = NUMBER_W'(3);
  localparam logic [NUMBER_W-1:0] W81 = NUMBER_W'(3 * 3 * 3 * 3);

  // The invalid trit pattern.
  localparam logic [1:0] TRIT_BAD = 2'd3;

  typedef struct packed {
    logic carry;
    logic sign;
  } tta_flags_t;

  typedef struct packed {
    logic [WORD_W-1:0]   result_word;
    logic [NUMBER_W-1:0] result_number;
    logic                compare_bit;
    logic                error_out;
  } tta_res_t;

  // Binary to packed trits, with the value taken modulo 81 first.
  // Each digit is found by at most two compare-and-subtract steps.
  function automatic logic [WORD_W-1:0] bin_to_trits(logic [NUMBER_W-1:0] n);
    logic [NUMBER_W-1:0] r;
    logic [1:0]          d3;
    logic [1:0]          d2;
    logic [1:0]          d1;
    r = (n >= W81) ? n - W81 : n;
    if (r >= W27 + W27) begin
      d3 = 2'd2;
      r  = r - (W27 + W27);
    end else if (r >= W27) begin
      d3 = 2'd1;
      r  = r - W27;
    end else begin
      d3 = 2'd0;
    end
    if (r >= W9 + W9) begin
      d2 = 2'd2;
      r  = r - (W9 + W9);
    end else if (r >= W9) begin
      d2 = 2'd1;
      r  = r - W9;
    end else begin
      d2 = 2'd0;
    end
    if (r >= W3 + W3) begin
      d1 = 2'd2;
      r  = r - (W3 + W3);
    end else if (r >= W3) begin
      d1 = 2'd1;
      r  = r - W3;
    end else begin
      d1 = 2'd0;
    end
    return {d3, d2, d1, r[1:0]};
  endfunction

  // Packed trits to binary; a pattern of 3 simply weighs 3.
  function automatic logic [NUMBER_W-1:0] trits_to_bin(logic [WORD_W-1:0] w);
    return NUMBER_W'(w[7:6]) * W27 + NUMBER_W'(w[5:4]) * W9
         + NUMBER_W'(w[3:2]) * W3 + NUMBER_W'(w[1:0]);
  endfunction

endpackage

### sv/tta_core.sv
`timescale 1ns / 1ps

// Combinational arithmetic for one registered operation.
module tta_core (
  input  logic [2:0]                kind,
  input  logic [tta_pkg::WORD_W-1:0] a_word,
  input  logic [tta_pkg::WORD_W-1:0] b_word,
  input  logic [6:0]                number_in,
  input  tta_pkg::tta_flags_t       flags,
  output tta_pkg::tta_res_t         res,
  output tta_pkg::tta_flags_t       flags_nxt
);
  import tta_pkg::*;

  logic              add_err;
  logic [TRITS:0]    add_c;
  logic [WORD_W-1:0] add_raw;
  logic [WORD_W-1:0] add_word;
  logic [2:0]        add_sum [TRITS];

  logic              a_lt_b;
  logic [WORD_W-1:0] sub_big;
  logic [WORD_W-1:0] sub_small;
  logic [1:0]        sub_s [TRITS];
  logic [TRITS-2:0]  sub_borrow;
  logic [WORD_W-1:0] sub_word;

  // Invalid trit detection for add.
  always_comb begin
    add_err = 1'b0;
    for (int i = 0; i < TRITS; i++) begin
      if (a_word[2*i +: 2] == TRIT_BAD || b_word[2*i +: 2] == TRIT_BAD) begin
        add_err = 1'b1;
      end
    end
  end

  // Ripple-carry ternary add, one trit per step.
  always_comb begin
    add_c[0] = 1'b0;
    for (int i = 0; i < TRITS; i++) begin
      add_sum[i]      = 3'(a_word[2*i +: 2]) + 3'(b_word[2*i +: 2]) + 3'(add_c[i]);
      add_c[i+1]      = (add_sum[i] >= 3'd3);
      add_raw[2*i +: 2] = add_c[i+1] ? 2'(add_sum[i] - 3'd3) : add_sum[i][1:0];
    end
    // A final carry drops the lowest trit and puts 1 in the top trit.
    if (add_c[TRITS]) begin
      add_word = {2'd1, add_raw[WORD_W-1:2]};
    end else begin
      add_word = add_raw;
    end
  end

  // Magnitude-ordered subtract with borrow rippled into the subtrahend.
  assign a_lt_b    = (a_word < b_word);
  assign sub_big   = a_lt_b ? b_word : a_word;
  assign sub_small = a_lt_b ? a_word : b_word;

  always_comb begin
    sub_s[0] = sub_small[1:0];
    for (int i = 0; i < TRITS - 1; i++) begin
      sub_borrow[i]      = (sub_big[2*i +: 2] < sub_s[i]);
      sub_s[i+1]         = sub_small[2*(i+1) +: 2] + 2'(sub_borrow[i]);
      sub_word[2*i +: 2] = sub_big[2*i +: 2] + (sub_borrow[i] ? 2'd3 : 2'd0) - sub_s[i];
    end
    sub_word[WORD_W-1:WORD_W-2]   = sub_big[WORD_W-1:WORD_W-2] - sub_s[TRITS-1];
  end

  // Operation select and flag update.
  always_comb begin
    res       = '0;
    flags_nxt = flags;
    case (kind)
      KIND_ADD: begin
        res.error_out = add_err;
        if (!add_err) begin
          res.result_word = add_word;
          if (add_c[TRITS]) begin
            flags_nxt.carry = 1'b1;
          end
        end
      end
      KIND_SUB: begin
        res.result_word = sub_word;
        flags_nxt.sign  = a_lt_b;
      end
      KIND_LESS: begin
        res.compare_bit = a_lt_b;
      end
      KIND_EQUAL: begin
        res.compare_bit = (a_word == b_word);
      end
      KIND_TO_TER: begin
        res.result_word = bin_to_trits(number_in);
      end
      KIND_TO_BIN: begin
        res.result_number = trits_to_bin(a_word);
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

### sv/ternary_tryte_alu.sv
`timescale 1ns / 1ps

// Ternary ALU for 4-trit words, two bits per trit, lowest trit in bits 1:0.
// Each operation is held in the input register after its transfer, then the
// arithmetic settles into the result register.
// A new operation is accepted every cycle; the result register decouples the
// two channels, so a held result stalls input only once the input register is
// also full. The carry flag is sticky until reset; the sign flag follows the
// most recent subtract. Both are reported with every result as they stand
// after that operation.
module ternary_tryte_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_kind,
  input  logic [tta_pkg::WORD_W-1:0]  in_a_word,
  input  logic [tta_pkg::WORD_W-1:0]  in_b_word,
  input  logic [6:0]                  in_number_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tta_pkg::WORD_W-1:0]  out_result_word,
  output logic [6:0]                  out_result_number,
  output logic                        out_compare_bit,
  output logic                        out_carry_out,
  output logic                        out_sign_out,
  output logic                        out_error_out
);
  import tta_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [2:0]        kind_r;
  logic [WORD_W-1:0] a_r;
  logic [WORD_W-1:0] b_r;
  logic [6:0]        num_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  tta_res_t          res_r;
  tta_flags_t        flags_r;
  tta_flags_t        flags_nxt;
  tta_flags_t        out_flags_r;
  tta_res_t          res_nxt;

  logic              in_fire;
  logic              advance;

  // Pipeline control.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_fire) begin
      kind_r <= in_kind;
      a_r    <= in_a_word;
      b_r    <= in_b_word;
      num_r  <= in_number_in;
    end
  end

  tta_core u_core (
    .kind      (kind_r),
    .a_word    (a_r),
    .b_word    (b_r),
    .number_in (num_r),
    .flags     (flags_r),
    .res       (res_nxt),
    .flags_nxt (flags_nxt)
  );

  // Flags and result register; flags move only when an operation enters the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance && s1_valid_r) begin
        flags_r <= flags_nxt;
      end
    end
    if (advance && s1_valid_r) begin
      res_r       <= res_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_word   = res_r.result_word;
  assign out_result_number = res_r.result_number;
  assign out_compare_bit   = res_r.compare_bit;
  assign out_error_out     = res_r.error_out;
  assign out_carry_out     = out_flags_r.carry;
  assign out_sign_out      = out_flags_r.sign;

`ifndef SYNTHESIS
  // The carry flag is sticky until reset.
  a_carry_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.carry |=> flags_r.carry)
    else $error("carry flag cleared without reset");

  // An add that raised an error returns a zero word.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_out) |-> (out_result_word == '0 && !out_compare_bit))
    else $error("error result carries data");

  // A comparison result never comes with a word result.
  a_cmp_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_bit) |-> (out_result_word == '0 && out_result_number == '0))
    else $error("compare bit set alongside a word result");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tta_pkg::*;

  // Kind codes that the block decodes as no operation.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int RADIX       = 3;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]          kind;
    logic [WORD_W-1:0]   a_word;
    logic [WORD_W-1:0]   b_word;
    logic [NUMBER_W-1:0] number_in;
  } alu_op_t;

  typedef struct packed {
    logic [WORD_W-1:0]   result_word;
    logic [NUMBER_W-1:0] result_number;
    logic                compare_bit;
    logic                carry_out;
    logic                sign_out;
    logic                error_out;
  } alu_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [2:0]          in_kind = '0;
  logic [WORD_W-1:0]   in_a_word = '0;
  logic [WORD_W-1:0]   in_b_word = '0;
  logic [NUMBER_W-1:0] in_number_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [WORD_W-1:0]   out_result_word;
  logic [NUMBER_W-1:0] out_result_number;
  logic                out_compare_bit;
  logic                out_carry_out;
  logic                out_sign_out;
  logic                out_error_out;

  alu_op_t     pending_ops[$];
  alu_result_t expected_results[$];
  alu_op_t     current_op;

  // Flags of the block as the predictor sees them.
  logic carry_state = 1'b0;
  logic sign_state  = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold      = 1'b0;
  int hold_count     = 0;
  int cycle_count    = 0;
  int errors         = 0;

  ternary_tryte_alu dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_a_word        (in_a_word),
    .in_b_word        (in_b_word),
    .in_number_in     (in_number_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_word  (out_result_word),
    .out_result_number(out_result_number),
    .out_compare_bit  (out_compare_bit),
    .out_carry_out    (out_carry_out),
    .out_sign_out     (out_sign_out),
    .out_error_out    (out_error_out)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Works out the result of one operation and advances the flags.
  function automatic alu_result_t alu_predict(alu_op_t op);
    alu_result_t       r;
    logic [1:0]        ta [TRITS];
    logic [1:0]        tb [TRITS];
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
    int                sum;
    int                carry;
    int                n;
    int                weight;
    bit                bad;
    r   = '0;
    bad = 1'b0;
    for (int i = 0; i < TRITS; i++) begin
      ta[i] = op.a_word[2*i +: 2];
      tb[i] = op.b_word[2*i +: 2];
      if (ta[i] == TRIT_BAD || tb[i] == TRIT_BAD) bad = 1'b1;
    end
    case (op.kind)
      KIND_ADD: begin
        if (bad) begin
          r.error_out = 1'b1;
        end else begin
          carry = 0;
          for (int i = 0; i < TRITS; i++) begin
            sum   = ta[i] + tb[i] + carry;
            carry = (sum >= RADIX) ? 1 : 0;
            r.result_word[2*i +: 2] = 2'(sum - RADIX * carry);
          end
          // A carry out of the top trit drops the lowest trit and sets the top to 1.
          if (carry != 0) begin
            carry_state   = 1'b1;
            r.result_word = {2'd1, r.result_word[WORD_W-1:2]};
          end
        end
      end
      KIND_SUB: begin
        sign_state = (op.a_word < op.b_word);
        hi = sign_state ? op.b_word : op.a_word;
        lo = sign_state ? op.a_word : op.b_word;
        for (int i = 0; i < TRITS; i++) begin
          ta[i] = hi[2*i +: 2];
          tb[i] = lo[2*i +: 2];
        end
        // Borrow bumps the next subtrahend trit, wrapping in its two bits.
        for (int i = 0; i < TRITS - 1; i++) begin
          if (ta[i] < tb[i]) begin
            r.result_word[2*i +: 2] = 2'(ta[i] + RADIX - tb[i]);
            tb[i+1] = tb[i+1] + 2'd1;
          end else begin
            r.result_word[2*i +: 2] = ta[i] - tb[i];
          end
        end
        r.result_word[WORD_W-1 -: 2] = ta[TRITS-1] - tb[TRITS-1];
      end
      KIND_LESS:  r.compare_bit = (op.a_word < op.b_word);
      KIND_EQUAL: r.compare_bit = (op.a_word == op.b_word);
      KIND_TO_TER: begin
        n = int'(op.number_in) % int'(W81);
        for (int i = 0; i < TRITS; i++) begin
          r.result_word[2*i +: 2] = 2'(n % RADIX);
          n = n / RADIX;
        end
      end
      KIND_TO_BIN: begin
        n      = 0;
        weight = 1;
        for (int i = 0; i < TRITS; i++) begin
          n      = n + ta[i] * weight;
          weight = weight * RADIX;
        end
        r.result_number = NUMBER_W'(n);
      end
      default: ;
    endcase
    r.carry_out = carry_state;
    r.sign_out  = sign_state;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    for (int i = 0; i < TRITS; i++) begin
      w[2*i +: 2] = ($urandom_range(19) == 0) ? TRIT_BAD : 2'($urandom_range(RADIX - 1));
    end
    return w;
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    if ($urandom_range(99) < 2) begin
      op.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    end else begin
      op.kind = 3'($urandom_range(int'(KIND_TO_BIN)));
    end
    op.a_word    = random_word();
    op.b_word    = ($urandom_range(9) < 2) ? op.a_word : random_word();
    op.number_in = ($urandom_range(9) == 0) ? NUMBER_W'($urandom)
                                            : NUMBER_W'($urandom_range(80));
    return op;
  endfunction

  function automatic void queue_op(logic [2:0] kind, logic [WORD_W-1:0] a,
                                   logic [WORD_W-1:0] b, logic [NUMBER_W-1:0] n);
    pending_ops.push_back('{kind: kind, a_word: a, b_word: b, number_in: n});
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // Driver: predicts each transfer and offers the next pending operation.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(alu_predict(current_op));
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          current_op = pending_ops.pop_front();
          in_valid     <= 1'b1;
          in_kind      <= current_op.kind;
          in_a_word    <= current_op.a_word;
          in_b_word    <= current_op.b_word;
          in_number_in <= current_op.number_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and drives the receiver's stalls.
  always @(posedge clk) begin : monitor
    alu_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no operation outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_word", int'(want.result_word), int'(out_result_word));
          check_field("result_number", int'(want.result_number), int'(out_result_number));
          check_field("compare_bit", int'(want.compare_bit), int'(out_compare_bit));
          check_field("carry_out", int'(want.carry_out), int'(out_carry_out));
          check_field("sign_out", int'(want.sign_out), int'(out_sign_out));
          check_field("error_out", int'(want.error_out), int'(out_error_out));
        end
      end
      if (long_hold && hold_count < HOLD_CYCLES) begin
        out_ready  <= 1'b0;
        hold_count <= hold_count + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random(int send_pct, int recv_pct, int count);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) pending_ops.push_back(random_op());
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Add: plain, invalid trit in either operand, carry out of the top trit.
    queue_op(KIND_ADD, 8'h66, 8'h11, '0);
    queue_op(KIND_ADD, 8'h03, 8'h00, '0);
    queue_op(KIND_ADD, 8'h00, 8'hC0, '0);
    queue_op(KIND_ADD, 8'hAA, 8'h01, '0);
    queue_op(KIND_ADD, 8'hAA, 8'hAA, '0);
    // Subtract: borrow chain, swapped operands, equal, invalid trits with wrap.
    queue_op(KIND_SUB, 8'h40, 8'h01, '0);
    queue_op(KIND_SUB, 8'h01, 8'h40, '0);
    queue_op(KIND_SUB, 8'h55, 8'h55, '0);
    queue_op(KIND_SUB, 8'hFF, 8'h00, '0);
    queue_op(KIND_SUB, 8'h00, 8'hFF, '0);
    queue_op(KIND_SUB, 8'hC0, 8'h3F, '0);
    // Compares, including invalid trits.
    queue_op(KIND_LESS, 8'h01, 8'h02, '0);
    queue_op(KIND_LESS, 8'h02, 8'h01, '0);
    queue_op(KIND_LESS, 8'hFF, 8'hFF, '0);
    queue_op(KIND_EQUAL, 8'hAA, 8'hAA, '0);
    queue_op(KIND_EQUAL, 8'h00, 8'hFF, '0);
    // Conversions at the edges of the range and beyond it.
    queue_op(KIND_TO_TER, 8'h00, 8'h00, 7'd0);
    queue_op(KIND_TO_TER, 8'h00, 8'h00, 7'd80);
    queue_op(KIND_TO_TER, 8'h00, 8'h00, 7'd81);
    queue_op(KIND_TO_TER, 8'h00, 8'h00, 7'd127);
    queue_op(KIND_TO_BIN, 8'hAA, 8'h00, '0);
    queue_op(KIND_TO_BIN, 8'hFF, 8'h00, '0);
    queue_op(KIND_TO_BIN, 8'h00, 8'h00, '0);
    // Kinds with no operation behind them.
    queue_op(KIND_SPARE_LO, 8'hFF, 8'hFF, 7'd127);
    queue_op(KIND_SPARE_HI, 8'hAA, 8'h55, 7'd64);
    wait_drained();

    // The receiver holds off for a long stretch while the sender keeps offering.
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold      = 1'b1;
    repeat (120) pending_ops.push_back(random_op());
    while (hold_count < HOLD_CYCLES) @(negedge clk);
    long_hold = 1'b0;
    wait_drained();

    run_random(0, 0, 350);
    run_random(68, 0, 350);
    run_random(0, 68, 350);
    run_random(8, 8, 350);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
